// File: sv/keypad_multitap_entry_core_macros.svh
// Assertion macros for the keypad multi-tap entry block.
// Uses the clk and rst_n names of the module that includes this header.
`ifndef KEYPAD_MULTITAP_ENTRY_CORE_MACROS_SVH
`define KEYPAD_MULTITAP_ENTRY_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KME_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kme assertion failed");

// next-cycle implication, disabled in reset
`define KME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kme assertion failed");

`endif

// File: sv/kme_pkg.sv
// Shared types, constants and key map for the keypad multi-tap entry block.
// No dependencies.
package kme_pkg;

    localparam int NUM_KEYS   = 16;
    localparam int MAX_TAPS   = 5;
    localparam int TIME_BITS  = 32;
    localparam int KEY_W      = 4;
    localparam int RKEY_W     = $clog2(NUM_KEYS + 1);
    localparam int CFG_W      = 16;
    localparam int CODE_W     = 8;
    localparam int CHAR_SLOTS = 8;
    localparam int TAP_W      = 3;
    localparam int LEN_W      = 4;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CODE_W-1:0] BACKSPACE_CODE = 8'd8;

    localparam logic [CFG_W-1:0] PROCESS_RST      = 16'd20;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd500;
    localparam logic [CFG_W-1:0] HOLD_RST         = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_LAT_RST     = 16'd200;

    typedef enum logic [1:0] {
        REG_PROCESS      = 2'd0,
        REG_DOUBLE_CLICK = 2'd1,
        REG_HOLD         = 2'd2,
        REG_HOLD_LATENCY = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       key_down;
        logic [1:0] key_row;
        logic [1:0] key_col;
    } tick_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              is_press;
        logic              last;
    } msg_t;

    typedef struct packed {
        logic [CFG_W-1:0] process_ticks;
        logic [CFG_W-1:0] double_click_ticks;
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] repeat_offset;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        msg_t       first;
        msg_t       second;
    } push_t;

    typedef struct packed {
        logic                             is_char;
        logic [LEN_W-1:0]                 len;
        logic [CHAR_SLOTS-1:0][CODE_W-1:0] chars;
    } key_entry_t;

    function automatic key_entry_t mk_entry(
        logic is_char, logic [LEN_W-1:0] len,
        logic [CODE_W-1:0] c0, logic [CODE_W-1:0] c1, logic [CODE_W-1:0] c2,
        logic [CODE_W-1:0] c3, logic [CODE_W-1:0] c4);
        key_entry_t e;
        e         = '0;
        e.is_char = is_char;
        e.len     = len;
        e.chars[0] = c0;
        e.chars[1] = c1;
        e.chars[2] = c2;
        e.chars[3] = c3;
        e.chars[4] = c4;
        return e;
    endfunction

    function automatic key_entry_t key_lookup(logic [KEY_W-1:0] k);
        key_entry_t e;
        unique case (k)
            4'd0:    e = mk_entry(1'b0, 4'd1, 8'd17, 8'd0, 8'd0, 8'd0, 8'd0);
            4'd1:    e = mk_entry(1'b0, 4'd1, 8'd19, 8'd0, 8'd0, 8'd0, 8'd0);
            4'd2:    e = mk_entry(1'b0, 4'd1, 8'd18, 8'd0, 8'd0, 8'd0, 8'd0);
            4'd3:    e = mk_entry(1'b0, 4'd1, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0);
            4'd4:    e = mk_entry(1'b1, 4'd4, "3", "D", "E", "F", 8'd0);
            4'd5:    e = mk_entry(1'b1, 4'd4, "6", "M", "N", "O", 8'd0);
            4'd6:    e = mk_entry(1'b1, 4'd5, "9", "W", "X", "Y", "Z");
            4'd7:    e = mk_entry(1'b0, 4'd1, 8'd13, 8'd0, 8'd0, 8'd0, 8'd0);
            4'd8:    e = mk_entry(1'b1, 4'd4, "2", "A", "B", "C", 8'd0);
            4'd9:    e = mk_entry(1'b1, 4'd4, "5", "J", "K", "L", 8'd0);
            4'd10:   e = mk_entry(1'b1, 4'd4, "8", "T", "U", "V", 8'd0);
            4'd11:   e = mk_entry(1'b1, 4'd2, "0", " ", 8'd0, 8'd0, 8'd0);
            4'd12:   e = mk_entry(1'b1, 4'd1, "1", 8'd0, 8'd0, 8'd0, 8'd0);
            4'd13:   e = mk_entry(1'b1, 4'd4, "4", "G", "H", "I", 8'd0);
            4'd14:   e = mk_entry(1'b1, 4'd5, "7", "P", "Q", "R", "S");
            default: e = mk_entry(1'b0, 4'd1, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0);
        endcase
        return e;
    endfunction

    // string length cut to MAX_TAPS, never zero
    function automatic logic [LEN_W-1:0] tap_len(key_entry_t e);
        logic [LEN_W-1:0] n;
        n = e.len;
        if (n > LEN_W'(MAX_TAPS)) n = LEN_W'(MAX_TAPS);
        if (n > LEN_W'(CHAR_SLOTS)) n = LEN_W'(CHAR_SLOTS);
        if (n == '0) n = LEN_W'(1);
        return n;
    endfunction

    function automatic logic [TAP_W-1:0] next_tap(key_entry_t e, logic [TAP_W-1:0] t);
        logic [LEN_W-1:0] nxt;
        nxt = LEN_W'(t) + LEN_W'(1);
        return (nxt >= tap_len(e)) ? '0 : nxt[TAP_W-1:0];
    endfunction

endpackage

// File: sv/keypad_multitap_entry_core.sv
// Multi-tap text entry for a 4x4 matrix keypad: one tick transaction in, zero to
// two key message transactions out (backspace then character on a repeat tap or
// auto repeat). A tick is taken into an input register, evaluated against the
// key state once the queue has room, and its messages enter a four-entry queue,
// from which they are sent on msg in order. Ticks are taken every cycle while
// the queue has room for two messages; the single message port sends one message
// a cycle while msg_ready is high, so a sustained rate of one tick per cycle
// holds only for ticks with at most one message; ticks that send two messages
// are limited by the message port. Configuration must be written over the APB
// port only while no tick is in flight; the block itself does not enforce this.
// Depends on kme_pkg, kme_cfg_regs, kme_eval and kme_out_queue.
module keypad_multitap_entry_core
    import kme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    input  tick_t              tick,
    output logic               msg_valid,
    input  logic               msg_ready,
    output msg_t               msg,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t  cfg;
    push_t push;
    logic  space_ok;

    assign pready = 1'b1;

    kme_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    kme_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .cfg        (cfg),
        .space_ok   (space_ok),
        .push       (push)
    );

    kme_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg)
    );

endmodule

// File: sv/kme_cfg_regs.sv
// APB-style configuration registers for the keypad multi-tap entry block.
// Depends on kme_pkg.
module kme_cfg_regs
    import kme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    logic [CFG_W-1:0] process_reg, process_next;
    logic [CFG_W-1:0] dbl_reg, dbl_next;
    logic [CFG_W-1:0] hold_reg, hold_next;
    logic [CFG_W-1:0] lat_reg, lat_next;
    logic [CFG_W-1:0] offset_reg, offset_next;
    logic [CFG_W-1:0] lat_eff;
    logic             wr_en;
    reg_idx_t         idx;

    assign wr_en = psel & penable & pwrite;
    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        process_next = process_reg;
        dbl_next     = dbl_reg;
        hold_next    = hold_reg;
        lat_next     = lat_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PROCESS:      process_next = pwdata[CFG_W-1:0];
                REG_DOUBLE_CLICK: dbl_next     = pwdata[CFG_W-1:0];
                REG_HOLD:         hold_next    = pwdata[CFG_W-1:0];
                REG_HOLD_LATENCY: lat_next     = pwdata[CFG_W-1:0];
                default:          process_next = process_reg;
            endcase
        end
    end

    // repeat rewinds press time by hold - min(latency, hold)
    assign lat_eff     = (lat_next > hold_next) ? hold_next : lat_next;
    assign offset_next = hold_next - lat_eff;

    always_comb
    begin
        unique case (idx)
            REG_PROCESS:      prdata = PDATA_W'(process_reg);
            REG_DOUBLE_CLICK: prdata = PDATA_W'(dbl_reg);
            REG_HOLD:         prdata = PDATA_W'(hold_reg);
            REG_HOLD_LATENCY: prdata = PDATA_W'(lat_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_reg <= PROCESS_RST;
            dbl_reg     <= DOUBLE_CLICK_RST;
            hold_reg    <= HOLD_RST;
            lat_reg     <= HOLD_LAT_RST;
            offset_reg  <= HOLD_RST - HOLD_LAT_RST;
        end
        else
        begin
            process_reg <= process_next;
            dbl_reg     <= dbl_next;
            hold_reg    <= hold_next;
            lat_reg     <= lat_next;
            offset_reg  <= offset_next;
        end
    end

    assign cfg.process_ticks      = process_reg;
    assign cfg.double_click_ticks = dbl_reg;
    assign cfg.hold_ticks         = hold_reg;
    assign cfg.repeat_offset      = offset_reg;

endmodule

// File: sv/kme_eval.sv
// Tick input register, key state and single-pass message evaluation.
// Depends on kme_pkg.
module kme_eval
    import kme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  tick_valid,
    output logic  tick_ready,
    input  tick_t tick,
    input  cfg_t  cfg,
    input  logic  space_ok,
    output push_t push
);

    logic                 in_valid_reg, in_valid_next;
    tick_t                in_data_reg;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] release_time_reg, release_time_next;
    logic                 pressed_reg, pressed_next;
    logic                 held_reg, held_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [RKEY_W-1:0]    rel_key_reg, rel_key_next;
    logic [TAP_W-1:0]     tap_reg, tap_next;

    logic                 fire;
    logic [KEY_W-1:0]     idx;
    logic [TIME_BITS-1:0] rel_el, press_el;
    logic                 lock_ok, dbl_ok, hold_ok;
    key_entry_t           k;
    logic                 bs, emit;
    logic [CODE_W-1:0]    ch;
    logic                 ch_press;

    assign fire       = in_valid_reg & space_ok;
    assign tick_ready = ~in_valid_reg | fire;
    assign in_valid_next = tick_ready ? tick_valid : in_valid_reg;

    assign idx      = {in_data_reg.key_row, in_data_reg.key_col};
    assign rel_el   = now_reg - release_time_reg;
    assign press_el = now_reg - press_time_reg;
    assign lock_ok  = {1'b0, rel_el} >= (TIME_BITS+1)'({cfg.process_ticks, 1'b0});
    assign dbl_ok   = rel_el < TIME_BITS'(cfg.double_click_ticks);
    assign hold_ok  = press_el > TIME_BITS'(cfg.hold_ticks);

    always_comb
    begin
        pressed_next      = pressed_reg;
        key_next          = key_reg;
        held_next         = held_reg;
        rel_key_next      = rel_key_reg;
        tap_next          = tap_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        bs                = 1'b0;
        emit              = 1'b0;
        ch_press          = 1'b1;

        if (in_data_reg.key_down && !pressed_reg)
        begin
            if (lock_ok && (RKEY_W'(idx) < RKEY_W'(NUM_KEYS)))
            begin
                pressed_next = 1'b1;
                key_next     = idx;
            end
        end
        else if (!in_data_reg.key_down && pressed_reg)
        begin
            pressed_next = 1'b0;
        end

        k = key_lookup(key_next);

        if (pressed_next)
        begin
            if (!held_reg)
            begin
                if (k.is_char && dbl_ok && (rel_key_reg == RKEY_W'(key_next)))
                begin
                    bs       = 1'b1;
                    tap_next = next_tap(k, tap_reg);
                end
                else
                begin
                    tap_next = '0;
                end
                emit            = 1'b1;
                press_time_next = now_reg;
                held_next       = 1'b1;
            end
            else if (hold_ok)
            begin
                if (k.is_char)
                begin
                    bs       = 1'b1;
                    tap_next = next_tap(k, tap_reg);
                end
                emit            = 1'b1;
                press_time_next = now_reg - TIME_BITS'(cfg.repeat_offset);
            end
        end
        else if (held_reg)
        begin
            held_next         = 1'b0;
            emit              = 1'b1;
            ch_press          = 1'b0;
            rel_key_next      = RKEY_W'(key_next);
            release_time_next = now_reg;
        end

        ch = ch_press ? k.chars[tap_next] : k.chars[0];
    end

    always_comb
    begin
        push.count           = fire ? (2'(bs) + 2'(emit)) : 2'd0;
        push.first.key_code  = bs ? BACKSPACE_CODE : ch;
        push.first.is_press  = bs | ch_press;
        push.first.last      = ~bs;
        push.second.key_code = ch;
        push.second.is_press = ch_press;
        push.second.last     = 1'b1;
    end

    assign now_next = now_reg + TIME_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (tick_ready)
        begin
            in_data_reg <= tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            now_reg          <= '0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            pressed_reg      <= 1'b0;
            held_reg         <= 1'b0;
            key_reg          <= '0;
            rel_key_reg      <= RKEY_W'(NUM_KEYS);
            tap_reg          <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                now_reg          <= now_next;
                press_time_reg   <= press_time_next;
                release_time_reg <= release_time_next;
                pressed_reg      <= pressed_next;
                held_reg         <= held_next;
                key_reg          <= key_next;
                rel_key_reg      <= rel_key_next;
                tap_reg          <= tap_next;
            end
        end
    end

endmodule

// File: sv/kme_out_queue.sv
// Small result queue: takes up to two messages a cycle, sends one while msg_ready is high.
// Depends on kme_pkg.
module kme_out_queue
    import kme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  space_ok,
    output logic  msg_valid,
    input  logic  msg_ready,
    output msg_t  msg
);

    msg_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] tail_plus1;
    logic                  pop;

    assign space_ok   = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign msg_valid  = count_reg != '0;
    assign msg        = mem_reg[head_reg];
    assign pop        = msg_valid & msg_ready;
    assign tail_plus1 = tail_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        head_next  = head_reg + FIFO_PTR_W'(pop);
        tail_next  = tail_reg + FIFO_PTR_W'(push.count);
        count_next = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/kme_checker.sv
// Port-level checks on the message channel of keypad_multitap_entry_core.
// Depends on kme_pkg and keypad_multitap_entry_core_macros.svh; bound to the top level.
`include "keypad_multitap_entry_core_macros.svh"

module kme_checker
    import kme_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic msg_valid,
    input logic msg_ready,
    input msg_t msg
);

    `KME_ASSERT_NEXT(a_msg_hold, msg_valid && !msg_ready, msg_valid && $stable(msg))
    `KME_ASSERT_NOW(a_release_last, msg_valid && !msg.is_press, msg.last)
    `KME_ASSERT_NOW(a_bs_not_last, msg_valid && msg.key_code == BACKSPACE_CODE, !msg.last)
    `KME_ASSERT_NEXT(a_pair_follows, msg_valid && msg_ready && !msg.last, msg_valid)
    `KME_ASSERT_NEXT(a_bs_then_press, msg_valid && msg_ready && !msg.last, msg.is_press)

endmodule

bind keypad_multitap_entry_core kme_checker u_kme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg)
);
